@@ hdl/inode_cache_get_put_assert.svh @@
// Assertion macros shared by the inode cache checker.
`ifndef INODE_CACHE_GET_PUT_ASSERT_SVH
`define INODE_CACHE_GET_PUT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ICG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("inode cache port check failed");

// Consequent holds in the cycle after the antecedent.
`define ICG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("inode cache port check failed");

`endif

@@ hdl/icg_pkg.sv @@
// Shared constants and control structs of the inode cache.
`timescale 1ns / 1ps
package icg_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam logic [15:0] LIMIT_RST = 16'd128;

  // Result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BUSY    = 3'd4;
  localparam logic [2:0] ST_PUT     = 3'd5;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic look;
    logic enc;
    logic get_exec;
    logic put_exec;
    logic put_link;
  } icg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_put;
    logic put_oob;
    logic invalid;
    logic any_hit;
    logic head_null;
    logic need_link;
  } icg_sts_t;

endpackage

@@ hdl/icg_ctrl.sv @@
// Sequencing controller of the inode cache.
`timescale 1ns / 1ps
module icg_ctrl
  import icg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output icg_cmd_t cmd_o,
  input  icg_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_ENC, S_GET, S_PUT, S_LINK, S_DONE
  } state_e;

  state_e state_q;
  logic   busy_q, done_q;

  // Commands follow the current state
  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == S_IDLE) && start;
    cmd_o.look     = (state_q == S_LOOK);
    cmd_o.enc      = (state_q == S_ENC);
    cmd_o.get_exec = (state_q == S_GET);
    cmd_o.put_exec = (state_q == S_PUT);
    cmd_o.put_link = (state_q == S_LINK);
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_LOOK;
            busy_q  <= 1'b1;
          end
        end
        S_LOOK: begin
          if (sts_i.is_put) begin
            if (sts_i.put_oob) begin
              state_q <= S_DONE;
              done_q  <= 1'b1;
            end else begin
              state_q <= S_PUT;
            end
          end else if (sts_i.invalid) begin
            state_q <= S_DONE;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_ENC;
          end
        end
        S_ENC: begin
          if (!sts_i.any_hit && sts_i.head_null) begin
            state_q <= S_DONE;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_GET;
          end
        end
        S_GET: begin
          state_q <= S_DONE;
          done_q  <= 1'b1;
        end
        S_PUT: begin
          if (sts_i.need_link) begin
            state_q <= S_LINK;
          end else begin
            state_q <= S_DONE;
            done_q  <= 1'b1;
          end
        end
        S_LINK: begin
          state_q <= S_DONE;
          done_q  <= 1'b1;
        end
        S_DONE: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

@@ hdl/icg_dpath.sv @@
// Tag match, slot tables, free list and result registers of the inode cache.
`timescale 1ns / 1ps
module icg_dpath
  import icg_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inode_limit_we_i,
  input  logic [15:0] inode_limit_i,
  input  logic        action_i,
  input  logic [7:0]  device_i,
  input  logic [15:0] inode_index_i,
  input  logic [5:0]  slot_in_i,
  input  logic        dirty_i,
  input  logic        link_zero_i,
  input  icg_cmd_t    cmd_i,
  output icg_sts_t    sts_o,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_out_o,
  output logic [7:0]  count_out_o,
  output logic        write_back_o,
  output logic        free_inode_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned PW = SW + 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // Request beat and config
  logic [15:0] limit_q;
  logic        action_q, dirty_q, lz_q;
  logic [7:0]  dev_q;
  logic [15:0] idx_q;
  logic [5:0]  slot_in_q;

  // Tag store (compared in parallel)
  logic [15:0]      tag_idx_q [SLOTS];
  logic [7:0]       tag_dev_q [SLOTS];
  logic [SLOTS-1:0] tag_vld_q, lock_q, onf_q;
  logic [SLOTS-1:0] match_d, match_q;

  // Count and link memories, entries invalid until first written
  logic [7:0]       cnt_mem [SLOTS];
  logic [PW-1:0]    nxt_mem [SLOTS];
  logic [PW-1:0]    prv_mem [SLOTS];
  logic [SLOTS-1:0] cnt_vld_q, nxt_vld_q, prv_vld_q;
  logic [7:0]       rd_cnt_q;
  logic [PW-1:0]    rd_nxt_q, rd_prv_q;
  logic             rd_cv_q, rd_nv_q, rd_pv_q;

  logic [PW-1:0] head_q, tail_q, old_tail_q;
  logic [SW-1:0] cur_s_q, enc_s, sel_s, put_s, rd_addr;
  logic          hit_q, any_hit, rd_en;

  logic [7:0]    cnt_rd, new_cnt;
  logic [PW-1:0] nxt_rd, prv_rd;

  logic          cnt_we, nxt_we, prv_we;
  logic [SW-1:0] cnt_wa, nxt_wa, prv_wa;
  logic [7:0]    cnt_wd;
  logic [PW-1:0] nxt_wd, prv_wd;

  logic          put_oob, invalid, put_zero;

  assign put_s   = SW'(slot_in_q);
  assign put_oob = (9'(slot_in_q) >= 9'(SLOTS));
  assign invalid = (idx_q == 16'd0) || (idx_q > limit_q);

  // Parallel tag compare
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_d[i] = tag_vld_q[i] && (tag_idx_q[i] == idx_q) && (tag_dev_q[i] == dev_q);
    end
  end

  // Lowest matching slot
  always_comb begin
    enc_s = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) enc_s = SW'(i);
    end
  end
  assign any_hit = |match_q;
  assign sel_s   = any_hit ? enc_s : head_q[SW-1:0];

  assign rd_en   = cmd_i.look || cmd_i.enc;
  assign rd_addr = cmd_i.enc ? sel_s : put_s;

  // Read data, with reset values for never-written entries
  assign cnt_rd = rd_cv_q ? rd_cnt_q : 8'd0;
  assign nxt_rd = rd_nv_q ? rd_nxt_q : (PW'(cur_s_q) + PW'(1));
  assign prv_rd = rd_pv_q ? rd_prv_q : ((cur_s_q == '0) ? NIL : (PW'(cur_s_q) - PW'(1)));

  // New count for get and put
  always_comb begin
    if (cmd_i.put_exec) begin
      new_cnt = (cnt_rd == 8'd0) ? 8'd0 : (cnt_rd - 8'd1);
    end else if (hit_q) begin
      new_cnt = (cnt_rd == 8'hFF) ? 8'hFF : (cnt_rd + 8'd1);
    end else begin
      new_cnt = 8'd1;
    end
  end
  assign put_zero = (new_cnt == 8'd0) && !onf_q[cur_s_q];

  assign sts_o.is_put    = action_q;
  assign sts_o.put_oob   = put_oob;
  assign sts_o.invalid   = invalid;
  assign sts_o.any_hit   = any_hit;
  assign sts_o.head_null = (head_q == NIL);
  assign sts_o.need_link = put_zero;

  // Memory write ports
  always_comb begin
    cnt_we = 1'b0; cnt_wa = cur_s_q; cnt_wd = new_cnt;
    nxt_we = 1'b0; nxt_wa = cur_s_q; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = cur_s_q; prv_wd = tail_q;
    if (cmd_i.get_exec && !(hit_q && lock_q[cur_s_q])) begin
      cnt_we = 1'b1;
      if (onf_q[cur_s_q]) begin
        nxt_we = (prv_rd != NIL);
        nxt_wa = prv_rd[SW-1:0];
        nxt_wd = nxt_rd;
        prv_we = (nxt_rd != NIL);
        prv_wa = nxt_rd[SW-1:0];
        prv_wd = prv_rd;
      end
    end else if (cmd_i.put_exec) begin
      cnt_we = 1'b1;
      nxt_we = put_zero;
      prv_we = put_zero;
    end else if (cmd_i.put_link) begin
      nxt_we = (old_tail_q != NIL);
      nxt_wa = old_tail_q[SW-1:0];
      nxt_wd = PW'(cur_s_q);
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (rd_en) begin
      rd_cnt_q <= cnt_mem[rd_addr];
      rd_nxt_q <= nxt_mem[rd_addr];
      rd_prv_q <= prv_mem[rd_addr];
    end
  end

  // Payload registers: request, tags, match, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q  <= action_i;
      dev_q     <= device_i;
      idx_q     <= inode_index_i;
      slot_in_q <= slot_in_i;
      dirty_q   <= dirty_i;
      lz_q      <= link_zero_i;
    end
    if (cmd_i.look) begin
      match_q <= match_d;
      cur_s_q <= put_s;
      if (action_q == ACT_PUT) begin
        status_o <= ST_PUT; slot_out_o <= slot_in_q;
      end else begin
        status_o <= ST_INVALID; slot_out_o <= '0;
      end
      count_out_o <= '0; write_back_o <= 1'b0; free_inode_o <= 1'b0;
    end
    if (cmd_i.enc) begin
      cur_s_q <= sel_s;
      hit_q   <= any_hit;
      status_o <= ST_FULL; slot_out_o <= '0; count_out_o <= '0;
    end
    if (cmd_i.get_exec) begin
      slot_out_o <= 6'(cur_s_q);
      if (hit_q && lock_q[cur_s_q]) begin
        status_o <= ST_BUSY; count_out_o <= cnt_rd;
      end else begin
        status_o <= hit_q ? ST_HIT : ST_MISS; count_out_o <= new_cnt;
        if (!hit_q) begin
          tag_idx_q[cur_s_q] <= idx_q;
          tag_dev_q[cur_s_q] <= dev_q;
        end
      end
    end
    if (cmd_i.put_exec) begin
      count_out_o  <= new_cnt;
      write_back_o <= (new_cnt == 8'd0) && dirty_q;
      free_inode_o <= (new_cnt == 8'd0) && lz_q;
      old_tail_q   <= tail_q;
    end
  end

  // Control state with reset: limit, flags, valid bits, list ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RST;
      tag_vld_q <= '0;
      lock_q    <= '0;
      onf_q     <= '1;
      cnt_vld_q <= '0;
      nxt_vld_q <= '0;
      prv_vld_q <= '0;
      rd_cv_q   <= 1'b0;
      rd_nv_q   <= 1'b0;
      rd_pv_q   <= 1'b0;
      head_q    <= '0;
      tail_q    <= PW'(SLOTS - 1);
    end else begin
      if (inode_limit_we_i) limit_q <= inode_limit_i;
      if (cnt_we) cnt_vld_q[cnt_wa] <= 1'b1;
      if (nxt_we) nxt_vld_q[nxt_wa] <= 1'b1;
      if (prv_we) prv_vld_q[prv_wa] <= 1'b1;
      if (rd_en) begin
        rd_cv_q <= cnt_vld_q[rd_addr];
        rd_nv_q <= nxt_vld_q[rd_addr];
        rd_pv_q <= prv_vld_q[rd_addr];
      end
      if (cmd_i.get_exec && !(hit_q && lock_q[cur_s_q])) begin
        lock_q[cur_s_q] <= 1'b1;
        if (!hit_q) tag_vld_q[cur_s_q] <= 1'b1;
        if (onf_q[cur_s_q]) begin
          onf_q[cur_s_q] <= 1'b0;
          if (prv_rd == NIL) head_q <= nxt_rd;
          if (nxt_rd == NIL) tail_q <= prv_rd;
        end
      end
      if (cmd_i.put_exec) begin
        lock_q[cur_s_q] <= 1'b0;
        if (put_zero) begin
          onf_q[cur_s_q] <= 1'b1;
          tail_q <= PW'(cur_s_q);
          if (tail_q == NIL) head_q <= PW'(cur_s_q);
        end
      end
    end
  end

endmodule

@@ hdl/inode_cache_get_put.sv @@
// Top level of the inode cache get/put block.
// Steps, accept to result: a get runs LOOK, ENC, GET; an invalid index ends after LOOK,
// a full table after ENC. A put runs LOOK, PUT (an out-of-range slot ends after LOOK),
// plus LINK when the slot goes back onto the free list (one write port per link memory).
// One beat at a time: busy is high from accept until the result cycle ends.
// Reset: asynchronous, clears all slots to empty and free, limit to 128; no clearing pass.
`timescale 1ns / 1ps
module inode_cache_get_put
  import icg_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inode_limit_we_i,
  input  logic [15:0] inode_limit_i,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [7:0]  device_i,
  input  logic [15:0] inode_index_i,
  input  logic [5:0]  slot_in_i,
  input  logic        dirty_i,
  input  logic        link_zero_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_out_o,
  output logic [7:0]  count_out_o,
  output logic        write_back_o,
  output logic        free_inode_o
);

  icg_cmd_t cmd;
  icg_sts_t sts;

  icg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  icg_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .inode_limit_we_i (inode_limit_we_i),
    .inode_limit_i    (inode_limit_i),
    .action_i         (action_i),
    .device_i         (device_i),
    .inode_index_i    (inode_index_i),
    .slot_in_i        (slot_in_i),
    .dirty_i          (dirty_i),
    .link_zero_i      (link_zero_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .slot_out_o       (slot_out_o),
    .count_out_o      (count_out_o),
    .write_back_o     (write_back_o),
    .free_inode_o     (free_inode_o)
  );

endmodule

@@ hdl/icg_checker.sv @@
// Port-level checker of the inode cache, bound to the top level.
`timescale 1ns / 1ps
`include "inode_cache_get_put_assert.svh"
module icg_checker
  import icg_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic [5:0] slot_out_o,
  input logic [7:0] count_out_o,
  input logic       write_back_o,
  input logic       free_inode_o
);

  // An accepted beat makes the block busy
  `ICG_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only appears while a beat is in flight
  `ICG_ASSERT_SAME(a_done_busy, done_o, busy)
  // One result strobe per beat, and the block frees up right after
  `ICG_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy)
  // Rejected gets carry no slot or count
  `ICG_ASSERT_SAME(a_reject_zero,
    done_o && (status_o == ST_INVALID || status_o == ST_FULL),
    slot_out_o == 6'd0 && count_out_o == 8'd0)
  // Flags come from puts only
  `ICG_ASSERT_SAME(a_flags_put, done_o && status_o != ST_PUT,
    !write_back_o && !free_inode_o)

endmodule

bind inode_cache_get_put icg_checker u_icg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .slot_out_o   (slot_out_o),
  .count_out_o  (count_out_o),
  .write_back_o (write_back_o),
  .free_inode_o (free_inode_o)
);

@@ sim/inode_cache_checker.sv @@
// Checker for the inode cache: predicts each result beat and compares it.
`timescale 1ns / 1ps
module inode_cache_checker
  import icg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inode_limit_we_i,
  input  logic [15:0] inode_limit_i,
  input  logic        start,
  input  logic        busy,
  input  logic        action_i,
  input  logic [7:0]  device_i,
  input  logic [15:0] inode_index_i,
  input  logic [5:0]  slot_in_i,
  input  logic        dirty_i,
  input  logic        link_zero_i,
  input  logic        done_o,
  input  logic [2:0]  status_o,
  input  logic [5:0]  slot_out_o,
  input  logic [7:0]  count_out_o,
  input  logic        write_back_o,
  input  logic        free_inode_o,
  output int          err_cnt_o,
  output int          pending_o
);

  localparam int NSLOT = 64;
  localparam int NIL   = NSLOT;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [7:0] count;
    logic       wb;
    logic       fr;
  } lookup_res_t;

  lookup_res_t res_q[$];

  // Shadow copy of the slot table
  logic [15:0] lim;
  logic [15:0] tag_idx [NSLOT];
  logic [7:0]  tag_dev [NSLOT];
  logic [7:0]  refs    [NSLOT];
  logic        locked  [NSLOT];
  logic        on_free [NSLOT];
  int          nxt     [NSLOT];
  int          prv     [NSLOT];
  int          head, tail;

  assign pending_o = res_q.size();

  task automatic table_reset();
    lim = LIMIT_RST;
    for (int i = 0; i < NSLOT; i++) begin
      tag_idx[i] = '0;
      tag_dev[i] = '0;
      refs[i]    = '0;
      locked[i]  = 1'b0;
      on_free[i] = 1'b1;
      nxt[i]     = i + 1;
      prv[i]     = (i == 0) ? NIL : i - 1;
    end
    head = 0;
    tail = NSLOT - 1;
  endtask

  task automatic free_unlink(int s);
    int p, n;
    p = prv[s];
    n = nxt[s];
    if (p < NSLOT) nxt[p] = n; else head = n;
    if (n < NSLOT) prv[n] = p; else tail = p;
    prv[s] = NIL;
    nxt[s] = NIL;
    on_free[s] = 1'b0;
  endtask

  task automatic free_append(int s);
    prv[s] = tail;
    nxt[s] = NIL;
    if (tail < NSLOT) nxt[tail] = s; else head = s;
    tail = s;
    on_free[s] = 1'b1;
  endtask

  // Work out the result of one accepted request and update the shadow table
  task automatic cache_access(output lookup_res_t r);
    int hit, s;
    r = '0;
    hit = NIL;
    if (action_i == ACT_GET) begin
      if (inode_index_i == 0 || inode_index_i > lim) begin
        r.status = ST_INVALID;
        return;
      end
      for (int i = 0; i < NSLOT; i++)
        if (hit == NIL && tag_idx[i] == inode_index_i && tag_dev[i] == device_i) hit = i;
      if (hit < NSLOT) begin
        r.slot = hit[5:0];
        if (locked[hit]) begin
          r.status = ST_BUSY;
          r.count  = refs[hit];
          return;
        end
        if (on_free[hit]) free_unlink(hit);
        if (refs[hit] != 8'hff) refs[hit] = refs[hit] + 8'd1;
        locked[hit] = 1'b1;
        r.status = ST_HIT;
        r.count  = refs[hit];
      end else if (head >= NSLOT) begin
        r.status = ST_FULL;
      end else begin
        s = head;
        free_unlink(s);
        tag_idx[s] = inode_index_i;
        tag_dev[s] = device_i;
        refs[s]    = 8'd1;
        locked[s]  = 1'b1;
        r.status = ST_MISS;
        r.slot   = s[5:0];
        r.count  = 8'd1;
      end
    end else begin
      s = slot_in_i;
      if (refs[s] != 0) refs[s] = refs[s] - 8'd1;
      if (refs[s] == 0) begin
        r.wb = dirty_i;
        r.fr = link_zero_i;
        if (!on_free[s]) free_append(s);
      end
      locked[s] = 1'b0;
      r.status = ST_PUT;
      r.slot   = slot_in_i;
      r.count  = refs[s];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t got, want;
    if (!rst_ni) begin
      table_reset();
      res_q.delete();
      err_cnt_o <= 0;
    end else begin
      // result beat
      if (done_o) begin
        got = '{status_o, slot_out_o, count_out_o, write_back_o, free_inode_o};
        if (res_q.size() == 0) begin
          if (err_cnt_o < 10) $display("unexpected result beat %p", got);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = res_q.pop_front();
          if (got !== want) begin
            if (err_cnt_o < 10) $display("mismatch: expected %p got %p", want, got);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      // request beat
      if (start && !busy) begin
        cache_access(want);
        res_q.push_back(want);
      end
      if (inode_limit_we_i) lim = inode_limit_i;
    end
  end

endmodule

@@ sim/inode_cache_get_put_tb.sv @@
// Testbench top: drives get/put requests and limit writes, reports the verdict.
`timescale 1ns / 1ps
module inode_cache_get_put_tb;
  import icg_pkg::*;

  logic        clk_i, rst_ni;
  logic        inode_limit_we_i;
  logic [15:0] inode_limit_i;
  logic        start, busy;
  logic        action_i;
  logic [7:0]  device_i;
  logic [15:0] inode_index_i;
  logic [5:0]  slot_in_i;
  logic        dirty_i, link_zero_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [5:0]  slot_out_o;
  logic [7:0]  count_out_o;
  logic        write_back_o, free_inode_o;
  int          err_cnt, pending;
  int          gap_pct;

  inode_cache_get_put dut (.*);
  inode_cache_checker chk (.*, .err_cnt_o(err_cnt), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // One request beat, with an optional idle gap in front
  task automatic send(logic act, logic [7:0] dev, logic [15:0] idx, logic [5:0] slot,
                      logic d, logic lz);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start         <= 1'b1;
    action_i      <= act;
    device_i      <= dev;
    inode_index_i <= idx;
    slot_in_i     <= slot;
    dirty_i       <= d;
    link_zero_i   <= lz;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    inode_limit_we_i <= 1'b1;
    inode_limit_i    <= v;
    @(posedge clk_i);
    inode_limit_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly gets on a small identity pool and puts of low slots
  task automatic traffic(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 45)
        send(ACT_GET, 8'($urandom_range(2)), 16'($urandom_range(1, 12)),
             6'($urandom), 1'($urandom), 1'($urandom));
      else if (kind < 85)
        send(ACT_PUT, 8'($urandom), 16'($urandom),
             6'($urandom_range(15)), 1'($urandom), 1'($urandom));
      else if (kind < 95)
        send(1'($urandom), 8'($urandom), 16'($urandom), 6'($urandom),
             1'($urandom), 1'($urandom));
      else begin
        // quiet point: let everything drain first
        drain();
        send(ACT_PUT, 8'($urandom), 16'($urandom), 6'($urandom),
             1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    inode_limit_we_i = 1'b0;
    inode_limit_i    = '0;
    start            = 1'b0;
    action_i         = ACT_GET;
    device_i         = '0;
    inode_index_i    = '0;
    slot_in_i        = '0;
    dirty_i          = 1'b0;
    link_zero_i      = 1'b0;
    gap_pct          = 12;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss, locked hit, puts to zero, hit from the free list, invalid indexes
    send(ACT_GET, 8'd0,   16'd1,     6'd0,  1'b0, 1'b0);
    send(ACT_GET, 8'd0,   16'd1,     6'd0,  1'b0, 1'b0);
    send(ACT_PUT, 8'd0,   16'd0,     6'd0,  1'b1, 1'b1);
    send(ACT_PUT, 8'd0,   16'd0,     6'd0,  1'b1, 1'b0);
    send(ACT_GET, 8'd0,   16'd1,     6'd0,  1'b0, 1'b0);
    send(ACT_PUT, 8'd0,   16'd0,     6'd0,  1'b0, 1'b1);
    send(ACT_GET, 8'd3,   16'd0,     6'd0,  1'b0, 1'b0);
    send(ACT_GET, 8'd3,   16'd129,   6'd0,  1'b0, 1'b0);
    send(ACT_GET, 8'd255, 16'd128,   6'd0,  1'b0, 1'b0);
    send(ACT_GET, 8'd255, 16'd65535, 6'd63, 1'b1, 1'b1);
    send(ACT_PUT, 8'd255, 16'hffff,  6'd63, 1'b1, 1'b1);
    send(ACT_PUT, 8'd0,   16'd0,     6'd1,  1'b0, 1'b0);

    // full table: lock every slot, two more misses, then release all
    set_limit(16'hffff);
    for (int i = 0; i < 66; i++)
      send(ACT_GET, 8'd200, 16'(1000 + i), 6'd0, 1'b0, 1'b0);
    for (int i = 0; i < 64; i++)
      send(ACT_PUT, 8'd0, 16'd0, 6'(i), 1'($urandom), 1'($urandom));

    traffic(200);
    gap_pct = 72;
    set_limit(16'd1);
    traffic(150);
    set_limit(16'($urandom_range(2, 65534)));
    traffic(100);
    gap_pct = 0;
    set_limit(16'd128);
    traffic(150);
    set_limit(16'hffff);
    traffic(100);

    drain();
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
